// ----- rtl/nmeack_pkg.sv -----
`default_nettype none

package nmeack_pkg;

  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] HEX_GAP     = 8'd7;

  localparam logic [7:0] LIMIT_RESET = 8'd120;

  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_MISMATCH  = 3'd1;
  localparam logic [2:0] STATUS_NO_STAR   = 3'd2;
  localparam logic [2:0] STATUS_TOO_LONG  = 3'd3;
  localparam logic [2:0] STATUS_NO_DIGITS = 3'd4;

  localparam logic REG_LENGTH_LIMIT = 1'b0;

  typedef enum logic [3:0] {
    PH_BODY = 4'b0001,
    PH_DIG1 = 4'b0010,
    PH_DIG2 = 4'b0100,
    PH_SKIP = 4'b1000
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] position;
    logic [7:0] running_xor;
    logic [7:0] high_digit;
  } sent_state_t;

  typedef struct packed {
    logic       sentence_ok;
    logic [2:0] status;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
  } result_t;

  localparam sent_state_t STATE_CLEAR = '{
    phase:       PH_BODY,
    position:    8'd0,
    running_xor: 8'd0,
    high_digit:  8'd0
  };

  // ASCII hex digit (0-9, uppercase A-F) to value; other characters wrap mod 256
  function automatic logic [7:0] digit_value(input logic [7:0] ch);
    logic [7:0] v;
    v = ch - CHAR_ZERO;
    if (ch < CHAR_ZERO || ch > CHAR_NINE) begin
      v = v - HEX_GAP;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/nmeack_step.sv -----
`default_nettype none

module nmeack_step (
  input  var nmeack_pkg::sent_state_t st,
  input  var logic [7:0]              ch,
  input  var logic [7:0]              length_limit,
  output var nmeack_pkg::sent_state_t st_next,
  output var logic                    emit,
  output var nmeack_pkg::result_t     res
);
  import nmeack_pkg::*;

  logic [7:0] hi_val;
  logic [7:0] lo_val;
  logic [7:0] rx;
  logic [2:0] status;

  assign hi_val = digit_value(st.high_digit);
  assign lo_val = digit_value(ch);
  assign rx     = {hi_val[3:0], 4'b0000} | lo_val;

  always_comb begin
    st_next = st;
    emit    = 1'b0;
    status  = STATUS_OK;
    res     = '0;
    unique case (st.phase)
      PH_BODY: begin
        if (ch == CHAR_NUL) begin
          emit    = 1'b1;
          status  = STATUS_NO_STAR;
          st_next = STATE_CLEAR;
        end else if (ch == CHAR_STAR) begin
          st_next.phase = PH_DIG1;
        end else if (st.position < length_limit) begin
          if (ch != CHAR_DOLLAR) begin
            st_next.running_xor = st.running_xor ^ ch;
          end
          st_next.position = st.position + 8'd1;
        end else begin
          emit          = 1'b1;
          status        = STATUS_TOO_LONG;
          st_next.phase = PH_SKIP;
        end
      end
      PH_DIG1: begin
        if (ch == CHAR_NUL) begin
          emit    = 1'b1;
          status  = STATUS_NO_DIGITS;
          st_next = STATE_CLEAR;
        end else begin
          st_next.high_digit = ch;
          st_next.phase      = PH_DIG2;
        end
      end
      PH_DIG2: begin
        emit = 1'b1;
        if (ch == CHAR_NUL) begin
          status  = STATUS_NO_DIGITS;
          st_next = STATE_CLEAR;
        end else begin
          status        = (rx == st.running_xor) ? STATUS_OK : STATUS_MISMATCH;
          res.received_sum = rx;
          st_next.phase = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (ch == CHAR_NUL) begin
          st_next = STATE_CLEAR;
        end
      end
      default: begin
        st_next = STATE_CLEAR;
      end
    endcase
    res.sentence_ok  = (status == STATUS_OK);
    res.status       = status;
    res.computed_sum = st.running_xor;
  end

endmodule

`default_nettype wire

// ----- rtl/nmea_sentence_checksum_check_core.sv -----
// Pipeline: a character accepted into the input stage has its result (if any)
//   registered into the output stage when it advances out of the input stage.
// Throughput: one character per cycle, unless a result waits on a stalled output.
// Reset (rst, synchronous, active high): empties both stages, clears the sentence
//   state, and sets length_limit to 120.
`default_nettype none

module nmea_sentence_checksum_check_core (
  input  var logic       clk,
  input  var logic       rst,
  input  var logic       psel,
  input  var logic       penable,
  input  var logic       pwrite,
  input  var logic       paddr,
  input  var logic [31:0] pwdata,
  output var logic [31:0] prdata,
  output var logic       pready,
  input  var logic       in_valid,
  output var logic       in_stall,
  input  var logic [7:0] character,
  output var logic       out_valid,
  input  var logic       out_stall,
  output var logic       sentence_ok,
  output var logic [2:0] status,
  output var logic [7:0] computed_sum,
  output var logic [7:0] received_sum
);
  import nmeack_pkg::*;

  logic        [7:0] length_limit;
  logic              s1_valid;
  logic        [7:0] s1_char;
  sent_state_t       state;
  sent_state_t       state_next;
  logic              emit;
  result_t           res;
  result_t           out_res;
  logic              advance;
  logic              accept_in;
  logic              cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr == REG_LENGTH_LIMIT) ? {24'd0, length_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_limit <= LIMIT_RESET;
    end else if (cfg_write && paddr == REG_LENGTH_LIMIT) begin
      length_limit <= pwdata[7:0];
    end
  end

  nmeack_step u_step (
    .st           (state),
    .ch           (s1_char),
    .length_limit (length_limit),
    .st_next      (state_next),
    .emit         (emit),
    .res          (res)
  );

  // A character with no result moves on even while the output slot is occupied
  assign advance   = s1_valid && (!emit || !out_valid || !out_stall);
  assign in_stall  = s1_valid && !advance;
  assign accept_in = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept_in) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      s1_char <= character;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_CLEAR;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_res <= res;
    end
  end

  assign sentence_ok  = out_res.sentence_ok;
  assign status       = out_res.status;
  assign computed_sum = out_res.computed_sum;
  assign received_sum = out_res.received_sum;

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_res))
    else $error("pending result overwritten");

  a_ok_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sentence_ok == (status == STATUS_OK)))
    else $error("sentence_ok disagrees with status");

  a_rx_only_decided: assert property (@(posedge clk) disable iff (rst)
    out_valid && received_sum != 8'd0 |-> status == STATUS_OK || status == STATUS_MISMATCH)
    else $error("received_sum set without checksum digits");

  a_star_limit: assert property (@(posedge clk) disable iff (rst)
    state.phase == PH_BODY |-> state.position <= length_limit || $past(cfg_write))
    else $error("body position passed the length limit");

endmodule

`default_nettype wire

// ----- verif/tb_nmea_sentence_checksum_check_core.sv -----
`default_nettype none

module tb_nmea_sentence_checksum_check_core;
  import nmeack_pkg::*;

  // Follows one sentence at a time and queues the verdict, if any, each character should cause.
  class checksum_tracker;
    logic [7:0] limit;
    phase_t     ph;
    logic [7:0] pos;
    logic [7:0] xsum;
    logic [7:0] hi_ch;
    result_t    verdicts_due[$];
    int         chars_taken;
    int         verdicts_checked;
    int         errors;
    int         per_status[8];

    function new();
      limit = LIMIT_RESET;
      clear_sentence();
    endfunction

    function void clear_sentence();
      ph    = PH_BODY;
      pos   = 8'd0;
      xsum  = 8'd0;
      hi_ch = 8'd0;
    endfunction

    // ASCII digit to value, letters shifted down past the gap after '9'
    function logic [7:0] nibble(logic [7:0] ch);
      logic [7:0] v;
      v = ch - CHAR_ZERO;
      if (ch < CHAR_ZERO || ch > CHAR_NINE) begin
        v = v - HEX_GAP;
      end
      return v;
    endfunction

    function void post(logic [2:0] st, logic [7:0] rx);
      result_t r;
      r.sentence_ok  = (st == STATUS_OK);
      r.status       = st;
      r.computed_sum = xsum;
      r.received_sum = rx;
      verdicts_due.push_back(r);
      per_status[st]++;
    endfunction

    function void take_char(logic [7:0] ch);
      logic [7:0] hv;
      logic [7:0] rx;
      chars_taken++;
      case (ph)
        PH_BODY: begin
          if (ch == CHAR_NUL) begin
            post(STATUS_NO_STAR, 8'd0);
            clear_sentence();
          end else if (ch == CHAR_STAR) begin
            ph = PH_DIG1;
          end else if (pos < limit) begin
            if (ch != CHAR_DOLLAR) begin
              xsum ^= ch;
            end
            pos++;
          end else begin
            post(STATUS_TOO_LONG, 8'd0);
            ph = PH_SKIP;
          end
        end
        PH_DIG1: begin
          if (ch == CHAR_NUL) begin
            post(STATUS_NO_DIGITS, 8'd0);
            clear_sentence();
          end else begin
            hi_ch = ch;
            ph    = PH_DIG2;
          end
        end
        PH_DIG2: begin
          if (ch == CHAR_NUL) begin
            post(STATUS_NO_DIGITS, 8'd0);
            clear_sentence();
          end else begin
            hv = nibble(hi_ch);
            rx = {hv[3:0], 4'h0} | nibble(ch);
            post((rx == xsum) ? STATUS_OK : STATUS_MISMATCH, rx);
            ph = PH_SKIP;
          end
        end
        default: begin
          if (ch == CHAR_NUL) begin
            clear_sentence();
          end
        end
      endcase
    endfunction

    function void match_verdict(result_t got);
      result_t want;
      if (verdicts_due.size() == 0) begin
        $error("verdict with none pending: status %0d computed %0h received %0h",
               got.status, got.computed_sum, got.received_sum);
        errors++;
        return;
      end
      want = verdicts_due.pop_front();
      verdicts_checked++;
      if (got.sentence_ok !== want.sentence_ok) begin
        $error("sentence_ok: expected %0d, got %0d", want.sentence_ok, got.sentence_ok);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.computed_sum !== want.computed_sum) begin
        $error("computed_sum: expected %0h, got %0h", want.computed_sum, got.computed_sum);
        errors++;
      end
      if (got.received_sum !== want.received_sum) begin
        $error("received_sum: expected %0h, got %0h", want.received_sum, got.received_sum);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst          = 1'b1;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic        paddr        = REG_LENGTH_LIMIT;
  logic [31:0] pwdata       = 32'd0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [7:0]  character    = 8'd0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic        sentence_ok;
  logic [2:0]  status;
  logic [7:0]  computed_sum;
  logic [7:0]  received_sum;

  checksum_tracker sb = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int limits_used    = 0;
  bit hold_req       = 1'b0;
  int hold_left      = 0;

  nmea_sentence_checksum_check_core dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // result side: check what was taken at this edge, then pick the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.match_verdict('{sentence_ok, status, computed_sum, received_sum});
    end
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_char(input logic [7:0] ch);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    character <= ch;
    do @(posedge clk); while (in_stall);
    sb.take_char(ch);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i]);
    end
    send_char(CHAR_NUL);
  endtask

  // let in-flight characters finish, including ones that cause no verdict
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.verdicts_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [7:0] v);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_LENGTH_LIMIT;
    pwdata  <= {24'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== v) begin
      $error("length_limit readback: expected %0d, got %0d", v, prdata[7:0]);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.limit = v;
    limits_used++;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? CHAR_ZERO + {4'd0, n} : CHAR_ZERO + {4'd0, n} + HEX_GAP;
  endfunction

  task automatic send_sentence();
    int         len;
    int         r;
    int         maxlen;
    bit         wide;
    logic [7:0] ch;
    logic [7:0] sum;
    logic [7:0] rx;
    r = $urandom_range(99);
    if (r < 12) begin
      // noise: any byte, zeros included
      repeat ($urandom_range(0, 12)) send_char(8'($urandom_range(255)));
      send_char(CHAR_NUL);
      return;
    end
    sum    = 8'd0;
    maxlen = (sb.limit < 12) ? sb.limit : 12;
    if ($urandom_range(9) == 0) begin
      len = int'(sb.limit) + $urandom_range(0, 2) - 1;
    end else begin
      len = $urandom_range(0, maxlen);
    end
    if (len < 0) begin
      len = 0;
    end
    for (int k = 0; k < len; k++) begin
      if (k == 0 && $urandom_range(3) != 0) begin
        ch = CHAR_DOLLAR;
      end else begin
        wide = ($urandom_range(19) == 0);
        do begin
          ch = wide ? 8'($urandom_range(1, 255)) : 8'($urandom_range(32, 126));
        end while (ch == CHAR_STAR);
      end
      if (ch != CHAR_DOLLAR) begin
        sum ^= ch;
      end
      send_char(ch);
    end
    r = $urandom_range(99);
    if (r >= 5) begin
      send_char(CHAR_STAR);
      if (r < 15) begin
        // digits cut short by the terminator
        if (r >= 10) begin
          send_char(hex_char(4'($urandom_range(15))));
        end
      end else begin
        if (r < 70) begin
          rx = sum;
        end else begin
          rx = 8'($urandom_range(255));
        end
        if (r < 85) begin
          send_char(hex_char(rx[7:4]));
          send_char(hex_char(rx[3:0]));
        end else begin
          send_char(8'($urandom_range(1, 255)));
          send_char(8'($urandom_range(1, 255)));
        end
        repeat ($urandom_range(0, 3)) send_char(8'($urandom_range(1, 255)));
      end
    end
    send_char(CHAR_NUL);
  endtask

  initial begin
    logic [7:0] limits[8];
    int         target;
    limits = '{8'd255, 8'd120, 8'd1, 8'd8, 8'd30, 8'($urandom_range(2, 254)), 8'd64, 8'd2};

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, at the reset limit
    send_text("$A*41");
    send_char(8'hFF);
    send_char(8'h01);
    send_text("*00");
    send_text("$GP");
    send_text("*");
    send_text("*4");
    send_text("$$*zz");

    // star right at the limit vs. one character too many
    write_limit(8'd1);
    send_text("AB*00");
    send_text("A*41");
    write_limit(8'd0);
    send_text("*00");
    send_text("A");

    target = sb.chars_taken;
    for (int p = 0; p < 8; p++) begin
      write_limit(limits[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      target += 140;
      while (sb.chars_taken < target) send_sentence();
    end

    // long receiver hold-off with the sender running flat out
    write_limit(8'd40);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b1;
    target += 150;
    while (sb.chars_taken < target) send_sentence();

    drain();
    repeat (6) @(posedge clk);
    $display("Sent %0d characters and checked %0d verdicts under %0d length limits.",
             sb.chars_taken, sb.verdicts_checked, limits_used);
    $display("Verdicts: ok %0d, mismatch %0d, no star %0d, too long %0d, digits missing %0d.",
             sb.per_status[STATUS_OK], sb.per_status[STATUS_MISMATCH],
             sb.per_status[STATUS_NO_STAR], sb.per_status[STATUS_TOO_LONG],
             sb.per_status[STATUS_NO_DIGITS]);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
